### hdl/all_pairs_box_overlap_detector_assert.svh
`ifndef ALL_PAIRS_BOX_OVERLAP_DETECTOR_ASSERT_SVH
`define ALL_PAIRS_BOX_OVERLAP_DETECTOR_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define APBOD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("apbod assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define APBOD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("apbod assertion failed");

`endif

### hdl/apbod_pkg.sv
package apbod_pkg;

   localparam int MAX_ENTITIES_DEFAULT = 32;

   typedef enum logic {
      CMD_ADD   = 1'b0,
      CMD_CLEAR = 1'b1
   } command_type;

   typedef struct packed {
      command_type        command;
      logic [15:0]        entity_id;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [14:0]        box_w;
      logic [14:0]        box_h;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] first_id;
      logic [15:0] second_id;
      logic        overflow;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        entity_id;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [14:0]        box_w;
      logic [14:0]        box_h;
   } entity_type;

endpackage

### hdl/apbod_ram.sv
module apbod_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### hdl/all_pairs_box_overlap_detector.sv
// Brute-force box collision detector. A start with command add tests the new entity against
// every stored entity in storage order, one table entry per cycle through the single read port
// of the entity memory, and then stores it if the table is not full. Busy stays high from the
// transfer through the scan, wait and finish states (only the finish state when the table is
// empty), and the next transfer can be taken as soon as busy falls. Each colliding pair
// is reported on rsp_strobe for one cycle as soon as the following pair is found, and the final
// result (a hit or a single no-hit result, marked by last) comes in the same cycle as busy falls.
// A clear command gives no result and leaves busy low. The receiver cannot stall, so every
// result must be taken in the cycle it is shown.
module all_pairs_box_overlap_detector #(
   parameter int MaxEntities = apbod_pkg::MAX_ENTITIES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  apbod_pkg::req_type req_data,
   output logic               rsp_strobe,
   output apbod_pkg::rsp_type rsp_data
);

`include "all_pairs_box_overlap_detector_assert.svh"

   localparam int AddrWidth  = $clog2(MaxEntities);
   localparam int CountWidth = $clog2(MaxEntities + 1);
   localparam int EntWidth   = $bits(apbod_pkg::entity_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [AddrWidth-1:0]   idx_ff, idx_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic                   pend_ff, pend_in;
   logic [15:0]            pend_id_ff, pend_id_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   apbod_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   apbod_pkg::req_type     req_ff, req_in;

   apbod_pkg::entity_type  wr_ent, rd_ent;
   logic [EntWidth-1:0]    rd_word;
   logic                   wr_en;
   logic                   full;
   logic                   accept;
   logic                   add_accept;
   logic                   match;
   logic [AddrWidth-1:0]   last_idx;
   logic signed [17:0]     sx, sy, sxe, sye, ox, oy, oxe, oye;

   apbod_ram #(
      .Width (EntWidth),
      .Depth (MaxEntities)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AddrWidth-1:0]),
      .wr_data (wr_ent),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (idx_ff),
      .rd_data (rd_word)
   );

   assign rd_ent = apbod_pkg::entity_type'(rd_word);
   assign wr_ent = '{entity_id: req_ff.entity_id, pos_x: req_ff.pos_x, pos_y: req_ff.pos_y,
                     pos_z: req_ff.pos_z, box_w: req_ff.box_w, box_h: req_ff.box_h};

   assign full       = (count_ff == CountWidth'(MaxEntities));
   assign accept     = start && (state_ff == ST_IDLE);
   assign add_accept = accept && (req_data.command == apbod_pkg::CMD_ADD);
   assign last_idx   = AddrWidth'(count_ff - CountWidth'(1));
   assign wr_en      = (state_ff == ST_FINISH) && !full;

   always_comb begin
      sx  = $signed({{2{rd_ent.pos_x[15]}}, rd_ent.pos_x}) + $signed({3'b000, rd_ent.box_w});
      sy  = $signed({{2{rd_ent.pos_y[15]}}, rd_ent.pos_y}) + $signed({3'b000, rd_ent.box_h});
      sxe = sx + $signed({3'b000, rd_ent.box_w});
      sye = sy + $signed({3'b000, rd_ent.box_h});
      ox  = $signed({{2{req_ff.pos_x[15]}}, req_ff.pos_x}) + $signed({3'b000, req_ff.box_w});
      oy  = $signed({{2{req_ff.pos_y[15]}}, req_ff.pos_y}) + $signed({3'b000, req_ff.box_h});
      oxe = ox + $signed({3'b000, req_ff.box_w});
      oye = oy + $signed({3'b000, req_ff.box_h});
      match = rd_valid_ff && (rd_ent.pos_z == req_ff.pos_z)
              && (rd_ent.entity_id != req_ff.entity_id)
              && (sx < oxe) && (ox < sxe) && (sy < oye) && (oy < sye);
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rd_valid_in   = (state_ff == ST_SCAN);
      pend_in       = pend_ff;
      pend_id_in    = pend_id_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      req_in        = req_ff;

      if (match) begin
         if (pend_ff) begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = '{hit: 1'b1, first_id: pend_id_ff, second_id: req_ff.entity_id,
                              overflow: full, last: 1'b0};
         end
         pend_in    = 1'b1;
         pend_id_in = rd_ent.entity_id;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               if (req_data.command == apbod_pkg::CMD_CLEAR) begin
                  count_in = '0;
               end else if (count_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
                  idx_in   = '0;
               end
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + AddrWidth'(1);
            if (idx_ff == last_idx) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            if (pend_ff) begin
               rsp_data_in = '{hit: 1'b1, first_id: pend_id_ff, second_id: req_ff.entity_id,
                               overflow: full, last: 1'b1};
            end else begin
               rsp_data_in = '{hit: 1'b0, first_id: 16'h0000, second_id: req_ff.entity_id,
                               overflow: full, last: 1'b1};
            end
            pend_in = 1'b0;
            if (!full) begin
               count_in = count_ff + CountWidth'(1);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_valid_ff   <= rd_valid_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      idx_ff      <= idx_in;
      pend_id_ff  <= pend_id_in;
      rsp_data_ff <= rsp_data_in;
      req_ff      <= req_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `APBOD_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CountWidth'(MaxEntities))
   `APBOD_ASSERT_SAME(a_idle_no_pending, clock, reset, state_ff == ST_IDLE, !pend_ff)
   `APBOD_ASSERT_SAME(a_read_in_scan, clock, reset, rd_valid_ff, busy && state_ff != ST_FINISH)
   `APBOD_ASSERT_SAME(a_nohit_is_last, clock, reset, rsp_strobe && !rsp_data.hit, rsp_data.last)
   `APBOD_ASSERT_NEXT(a_add_goes_busy, clock, reset, add_accept, busy)

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int MAX_ENT = apbod_pkg::MAX_ENTITIES_DEFAULT;
   localparam int RANDOM_ITEMS = 92;
   localparam int SETTLE_CYCLES = 80;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      apbod_pkg::req_type item;
      bit                 fixed;
      apbod_pkg::rsp_type reply;
   } directed_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   apbod_pkg::req_type req_data;
   logic               rsp_strobe;
   apbod_pkg::rsp_type rsp_data;

   apbod_pkg::rsp_type    awaited_pairs[$];
   apbod_pkg::entity_type frame_table[MAX_ENT];
   int                    frame_count;
   int                    mismatches;
   int                    cycle_count;

   all_pairs_box_overlap_detector uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bit spans_cross(input int s1, input int l1, input int s2, input int l2);
      return (s1 < s2 + l2) && (s2 < s1 + l1);
   endfunction

   function automatic void apply_item(input apbod_pkg::req_type item,
                                      output apbod_pkg::rsp_type found[$]);
      int                 nx, ny, nw, nh, sx, sy, sw, sh, i;
      bit                 full;
      apbod_pkg::rsp_type r;
      found = {};
      if (item.command == apbod_pkg::CMD_CLEAR) begin
         frame_count = 0;
         return;
      end
      nw = int'(item.box_w);
      nh = int'(item.box_h);
      nx = int'(item.pos_x);
      ny = int'(item.pos_y);
      nx = nx + nw;
      ny = ny + nh;
      full = frame_count >= MAX_ENT;
      for (i = 0; i < frame_count; i++) begin
         if (frame_table[i].pos_z == item.pos_z && frame_table[i].entity_id != item.entity_id)
         begin
            sw = int'(frame_table[i].box_w);
            sh = int'(frame_table[i].box_h);
            sx = int'(frame_table[i].pos_x);
            sy = int'(frame_table[i].pos_y);
            sx = sx + sw;
            sy = sy + sh;
            if (spans_cross(sx, sw, nx, nw) && spans_cross(sy, sh, ny, nh)) begin
               r = '{1'b1, frame_table[i].entity_id, item.entity_id, full, 1'b0};
               found = {found, r};
            end
         end
      end
      if (found.size() == 0) begin
         r = '{1'b0, 16'd0, item.entity_id, full, 1'b0};
         found = {found, r};
      end
      found[found.size() - 1].last = 1'b1;
      if (!full) begin
         frame_table[frame_count] = '{item.entity_id, item.pos_x, item.pos_y, item.pos_z,
                                      item.box_w, item.box_h};
         frame_count++;
      end
   endfunction

   function automatic apbod_pkg::req_type random_entity(input bit tidy);
      apbod_pkg::req_type item;
      if (tidy) begin
         item.command = apbod_pkg::CMD_ADD;
         item.entity_id = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(1, 24));
         item.pos_x = 16'(int'($urandom_range(0, 80)) - 40);
         item.pos_y = 16'(int'($urandom_range(0, 80)) - 40);
         item.pos_z = 16'(int'($urandom_range(0, 2)) - 1);
         item.box_w = 15'($urandom_range(0, 30));
         item.box_h = 15'($urandom_range(0, 30));
      end else begin
         item.command = ($urandom_range(0, 3) == 0) ? apbod_pkg::CMD_CLEAR
                                                    : apbod_pkg::CMD_ADD;
         item.entity_id = 16'($urandom);
         item.pos_x = 16'($urandom);
         item.pos_y = 16'($urandom);
         item.pos_z = 16'($urandom);
         item.box_w = 15'($urandom);
         item.box_h = 15'($urandom);
      end
      return item;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
      mismatches++;
   endtask

   task automatic send_item(input apbod_pkg::req_type item, input bit may_idle, input bit fixed,
                            input apbod_pkg::rsp_type reply);
      apbod_pkg::rsp_type found[$];
      @(negedge clock);
      req_data <= item;
      start <= !(may_idle && $urandom_range(99) < 31);
      forever begin
         @(posedge clock);
         if (start === 1'b1 && busy === 1'b0) break;
         @(negedge clock);
         start <= !(may_idle && $urandom_range(99) < 31);
      end
      apply_item(item, found);
      if (fixed) begin
         awaited_pairs = {awaited_pairs, reply};
      end else begin
         awaited_pairs = {awaited_pairs, found};
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** all_pairs_box_overlap_detector: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_check
      apbod_pkg::rsp_type want;
      if (reset === 1'b0 && rsp_strobe !== 1'b0) begin
         if (awaited_pairs.size() == 0) begin
            report_mismatch("result with no transfer awaiting it, second_id",
                            32'(rsp_data.second_id), 32'd0);
         end else begin
            want = awaited_pairs.pop_front();
            if (rsp_data.hit !== want.hit)
               report_mismatch("hit", 32'(rsp_data.hit), 32'(want.hit));
            if (rsp_data.first_id !== want.first_id)
               report_mismatch("first_id", 32'(rsp_data.first_id), 32'(want.first_id));
            if (rsp_data.second_id !== want.second_id)
               report_mismatch("second_id", 32'(rsp_data.second_id), 32'(want.second_id));
            if (rsp_data.overflow !== want.overflow)
               report_mismatch("overflow", 32'(rsp_data.overflow), 32'(want.overflow));
            if (rsp_data.last !== want.last)
               report_mismatch("last", 32'(rsp_data.last), 32'(want.last));
         end
      end
   end

   initial begin
      directed_row_type   script[];
      apbod_pkg::req_type item;
      int                 sent;
      int                 frame;
      int                 frame_len;
      int                 j;
      mismatches = 0;
      cycle_count = 0;
      frame_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      script = '{
         '{'{apbod_pkg::CMD_ADD, 16'd1, 16'sd0, 16'sd0, 16'sd0, 15'd10, 15'd10}, 1'b1,
           '{1'b0, 16'd0, 16'd1, 1'b0, 1'b1}},
         '{'{apbod_pkg::CMD_ADD, 16'd2, 16'sd5, 16'sd5, 16'sd0, 15'd10, 15'd10}, 1'b0, '0},
         '{'{apbod_pkg::CMD_ADD, 16'd1, 16'sd3, 16'sd3, 16'sd0, 15'd10, 15'd10}, 1'b0, '0},
         '{'{apbod_pkg::CMD_ADD, 16'd3, 16'sd5, 16'sd5, 16'sd1, 15'd10, 15'd10}, 1'b1,
           '{1'b0, 16'd0, 16'd3, 1'b0, 1'b1}},
         '{'{apbod_pkg::CMD_ADD, 16'd4, 16'sd10, 16'sd0, 16'sd0, 15'd10, 15'd10}, 1'b0, '0},
         '{'{apbod_pkg::CMD_ADD, 16'd5, 16'sd12, 16'sd12, 16'sd0, 15'd0, 15'd0}, 1'b0, '0},
         '{'{apbod_pkg::CMD_CLEAR, 16'hABCD, 16'h1234, 16'h5678, 16'h0000,
             15'h1111, 15'h2222}, 1'b0, '0},
         '{'{apbod_pkg::CMD_ADD, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
             15'h7FFF, 15'h7FFF}, 1'b1,
           '{1'b0, 16'd0, 16'hFFFF, 1'b0, 1'b1}},
         '{'{apbod_pkg::CMD_ADD, 16'h0000, 16'h8000, 16'h8000, 16'h8000,
             15'h7FFF, 15'h7FFF}, 1'b1,
           '{1'b0, 16'd0, 16'h0000, 1'b0, 1'b1}},
         '{'{apbod_pkg::CMD_ADD, 16'd7, 16'h7FFF, 16'h7FFF, 16'h7FFF,
             15'h7FFF, 15'h7FFF}, 1'b0, '0},
         '{'{apbod_pkg::CMD_ADD, 16'd8, 16'h8000, 16'h8000, 16'h8000, 15'd1, 15'd1}, 1'b0, '0},
         '{'{apbod_pkg::CMD_ADD, 16'd9, 16'h0000, 16'h0000, 16'h8000,
             15'd100, 15'd100}, 1'b0, '0},
         '{'{apbod_pkg::CMD_ADD, 16'd10, 16'h8000, 16'h0000, 16'h8000,
             15'd0, 15'h7FFF}, 1'b0, '0},
         '{'{apbod_pkg::CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
             15'd0, 15'd0}, 1'b0, '0},
         '{'{apbod_pkg::CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
             15'h7FFF, 15'h7FFF}, 1'b0, '0},
         '{'{apbod_pkg::CMD_ADD, 16'h5A5A, 16'hA5A5, 16'h5A5A, 16'h0000,
             15'h5555, 15'h2AAA}, 1'b1,
           '{1'b0, 16'd0, 16'h5A5A, 1'b0, 1'b1}},
         '{'{apbod_pkg::CMD_ADD, 16'hA5A5, 16'hA5A5, 16'h5A5A, 16'h0000,
             15'h2AAA, 15'h5555}, 1'b0, '0},
         '{'{apbod_pkg::CMD_ADD, 16'h5A5A, 16'hA5A0, 16'h5A50, 16'h0000,
             15'h2AAA, 15'h5555}, 1'b0, '0}
      };
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[r]) send_item(script[r].item, 1'b1, script[r].fixed, script[r].reply);

      sent = 0;
      frame = 0;
      while (sent < RANDOM_ITEMS) begin
         item = random_entity(1'b0);
         item.command = apbod_pkg::CMD_CLEAR;
         send_item(item, !(sent >= 40 && sent < 75), 1'b0, '0);
         sent++;
         if (frame == 0) frame_len = MAX_ENT + 4;
         else if ($urandom_range(0, 5) == 0) frame_len = $urandom_range(MAX_ENT + 1, MAX_ENT + 6);
         else frame_len = $urandom_range(2, 12);
         for (j = 0; j < frame_len && sent < RANDOM_ITEMS; j++) begin
            item = random_entity($urandom_range(99) < 85);
            send_item(item, !(sent >= 40 && sent < 75), 1'b0, '0);
            sent++;
         end
         frame++;
      end

      @(negedge clock);
      start <= 1'b0;
      while (awaited_pairs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("** all_pairs_box_overlap_detector: PASSED **");
      end else begin
         $display("** all_pairs_box_overlap_detector: FAILED **");
      end
      $finish;
   end
endmodule
